// File: rtl/core/fft_pkg.sv
// Shared types and codes for the first-fit region table.
package fft_pkg;

	localparam int KEY_W  = 32;
	localparam int ADDR_W = 16;
	localparam int MEMB_W = 17;

	typedef enum logic [2:0] {
		ACT_STORE  = 3'd0,
		ACT_LOOKUP = 3'd1,
		ACT_ERASE  = 3'd2,
		ACT_COPY   = 3'd3,
		ACT_RENAME = 3'd4,
		ACT_LFREE  = 3'd5,
		ACT_PACK   = 3'd6,
		ACT_NOP    = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_EXISTS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [KEY_W-1:0]  name_key;
		logic [KEY_W-1:0]  new_name_key;
		logic [ADDR_W-1:0] request_length;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] start_address;
		logic [ADDR_W-1:0] region_length;
		logic [MEMB_W-1:0] largest_gap;
	} rsp_t;

endpackage

// File: rtl/core/first_fit_region_table_top.sv
// First-fit region table: top level with sequencer and entry memory.
//
//  channel   signals                       direction  notes
//  request   start, busy, req              in/out     taken when start && !busy
//  result    done, rsp                     out        one-cycle strobe, no stall
//  config    cfg_we, cfg_data              in         memory_bytes, written at once
//
// One request at a time. Each pass over the table reads one entry at a time, in a read
// state and a check state, from the entry memory (one write port, registered read); the
// duplicate key scan streams one entry per cycle. Busy is shortest for a no-op, or for
// pack or largest free on an empty table, and longest for copy (key scan, gap scan,
// duplicate scan, insert search/shift).
// Reset clears the entry count and the sequencer; memory contents are never
// cleared, only entries below the count are read.
// The result strobe cannot be held off; busy drops in the cycle after it.
module first_fit_region_table_top #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  fft_pkg::req_t         req,
	output logic                  done,
	output fft_pkg::rsp_t         rsp,
	input  logic                  cfg_we,
	input  logic [16:0]           cfg_data
);
	import fft_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = KEY_W + 2 * ADDR_W;
	localparam int SW = ADDR_W + CW;
	localparam logic [MEMB_W-1:0] SPAN = MEMB_W'(1) << ADDR_W;
	localparam logic [SW-1:0]     SUM_SPAN = SW'(1) << ADDR_W;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] st;
		logic [ADDR_W-1:0] len;
	} ent_t;

	typedef enum logic [4:0] {
		S_IDLE, S_KRD, S_KCHK, S_K2RD, S_K2CHK,
		S_GRD, S_GCHK, S_GTAIL,
		S_PRD, S_PCHK, S_SHRD, S_SHWR, S_INS,
		S_ERD, S_EWR, S_REN, S_PKRD, S_PKWR, S_DONE
	} state_t;

	// entry memory
	ent_t mem [MAX_ENTRIES];
	logic          we;
	logic [IW-1:0] waddr, raddr;
	ent_t          wdata, rdata;
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	state_t            state_q;
	logic [MEMB_W-1:0] memb_q;
	logic [CW-1:0]     cnt_q, idx_q;
	req_t              req_q;
	logic [ADDR_W-1:0] len_q;       // length to place
	logic [KEY_W-1:0]  pkey_q;      // key to place
	logic [IW-1:0]     fidx_q;
	ent_t              fent_q;
	logic [MEMB_W-1:0] pend_q;      // end of previous entry
	logic [MEMB_W-1:0] best_q;
	logic [ADDR_W-1:0] where_q;
	logic              fit_q;
	logic [SW-1:0]     sum_q;       // running pack address, wide enough for all lengths
	rsp_t              rsp_q;
	logic              done_q;

	logic [MEMB_W-1:0] lim, rst_ext, rend, gap;
	logic              gap_ok;
	assign lim     = (memb_q < SPAN) ? memb_q : SPAN;
	assign rst_ext = MEMB_W'(rdata.st);
	assign rend    = rst_ext + MEMB_W'(rdata.len);
	assign gap     = rst_ext - pend_q;
	assign gap_ok  = (rst_ext >= pend_q) && (gap >= MEMB_W'(len_q))
		&& (pend_q + MEMB_W'(len_q) <= lim);

	logic [IW-1:0] idx_a;
	assign idx_a = idx_q[IW-1:0];

	always_comb begin
		raddr = idx_a;
		we    = 1'b0;
		waddr = idx_a;
		wdata = rdata;
		unique case (state_q)
			S_SHWR: begin
				we = 1'b1;
				waddr = IW'(idx_q + CW'(1));
			end
			S_INS: begin
				we = 1'b1;
				wdata = '{key: pkey_q, st: where_q, len: len_q};
			end
			S_EWR: begin
				we = 1'b1;
				waddr = IW'(idx_q - CW'(1));
			end
			S_REN: begin
				we = 1'b1;
				waddr = fidx_q;
				wdata = '{key: req_q.new_name_key, st: fent_q.st, len: fent_q.len};
			end
			S_PKWR: begin
				we = 1'b1;
				wdata.st = (sum_q < SUM_SPAN) ? sum_q[ADDR_W-1:0] : {ADDR_W{1'b1}};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			memb_q  <= SPAN;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) memb_q <= cfg_data;
			unique case (state_q)
				S_IDLE: if (start && !busy) begin
					req_q  <= req;
					rsp_q  <= '0;
					idx_q  <= '0;
					fit_q  <= 1'b0;
					len_q  <= req.request_length;
					pkey_q <= req.name_key;
					unique case (action_t'(req.action))
						ACT_LFREE: begin
							best_q <= lim;
							pend_q <= '0;
							// empty table: the whole memory is one gap
							if (cnt_q == '0) rsp_q.largest_gap <= lim;
							state_q <= (cnt_q == '0) ? S_DONE : S_GRD;
						end
						ACT_PACK: begin
							sum_q <= '0;
							state_q <= (cnt_q == '0) ? S_DONE : S_PKRD;
						end
						ACT_NOP: state_q <= S_DONE;
						ACT_STORE: begin
							pend_q <= '0;
							fit_q  <= 1'b0;
							if (MEMB_W'(req.request_length) > lim) begin
								rsp_q.status <= ST_NO_SPACE;
								state_q <= S_DONE;
							end else if (cnt_q == '0) begin
								where_q <= '0; fit_q <= 1'b1;
								state_q <= S_K2RD;
							end else state_q <= S_GRD;
						end
						default: state_q <= (cnt_q == '0) ? S_KCHK : S_KRD;
					endcase
				end
				// scan for name_key
				S_KRD: state_q <= S_KCHK;
				S_KCHK: begin
					if (idx_q < cnt_q && rdata.key == req_q.name_key) begin
						fidx_q <= idx_a; fent_q <= rdata;
						state_q <= S_K2RD;
					end else if (idx_q + CW'(1) < cnt_q) begin
						idx_q <= idx_q + CW'(1); state_q <= S_KRD;
					end else state_q <= S_K2RD;
					if (!(idx_q < cnt_q && rdata.key == req_q.name_key)
						&& !(idx_q + CW'(1) < cnt_q)) begin
						rsp_q.status <= ST_NOTFOUND;
						state_q <= S_DONE;
					end
				end
				// key found or space found, dispatch
				S_K2RD: begin
					if (req_q.action == ACT_STORE || fit_q) begin
						// space found for store or copy: duplicate check next
						idx_q <= '0; state_q <= S_K2CHK;
					end else begin
						rsp_q.start_address <= fent_q.st;
						rsp_q.region_length <= fent_q.len;
						unique case (action_t'(req_q.action))
							ACT_LOOKUP: state_q <= S_DONE;
							ACT_ERASE: begin
								idx_q <= CW'(fidx_q) + CW'(1);
								state_q <= S_ERD;
							end
							ACT_COPY: begin
								rsp_q.start_address <= '0;
								rsp_q.region_length <= '0;
								if (fent_q.len == '0) state_q <= S_DONE;
								else if (MEMB_W'(fent_q.len) > lim) begin
									rsp_q.status <= ST_NO_SPACE; state_q <= S_DONE;
								end else begin
									len_q <= fent_q.len;
									pkey_q <= req_q.new_name_key;
									pend_q <= '0; fit_q <= 1'b0; idx_q <= '0;
									state_q <= S_GRD;
								end
							end
							default: begin // rename
								rsp_q.start_address <= '0;
								rsp_q.region_length <= '0;
								pkey_q <= req_q.new_name_key;
								idx_q <= '0; state_q <= S_K2CHK;
							end
						endcase
					end
				end
				// duplicate scan on pkey_q (rdata holds the entry whose read was issued in the cycle before)
				S_K2CHK: begin
					if (cnt_q == '0) begin
						state_q <= S_PRD;
					end else if (idx_q != '0 && rdata.key == pkey_q) begin
						rsp_q.status <= ST_EXISTS; state_q <= S_DONE;
					end else if (idx_q < cnt_q) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						if (req_q.action == ACT_RENAME) state_q <= S_REN;
						else if (cnt_q == CW'(MAX_ENTRIES)) begin
							rsp_q.status <= ST_FULL; state_q <= S_DONE;
						end else begin
							idx_q <= '0; state_q <= S_PRD;
						end
					end
				end
				S_REN: begin
					rsp_q.start_address <= fent_q.st;
					rsp_q.region_length <= fent_q.len;
					state_q <= S_DONE;
				end
				// gap scan: first fit or largest free
				S_GRD: state_q <= S_GCHK;
				S_GCHK: begin
					if (req_q.action == ACT_LFREE) begin
						if (idx_q == '0) begin
							if (rst_ext < best_q) best_q <= rst_ext;
						end else if (rst_ext > pend_q && gap > best_q) best_q <= gap;
						pend_q <= rend;
						if (idx_q + CW'(1) < cnt_q) begin
							idx_q <= idx_q + CW'(1); state_q <= S_GRD;
						end else state_q <= S_GTAIL;
					end else begin
						if (idx_q == '0 ? (rst_ext >= MEMB_W'(len_q)) : gap_ok) begin
							where_q <= (idx_q == '0) ? '0 : pend_q[ADDR_W-1:0];
							fit_q <= 1'b1;
							idx_q <= '0; state_q <= S_K2RD;
						end else begin
							pend_q <= rend;
							if (idx_q + CW'(1) < cnt_q) begin
								idx_q <= idx_q + CW'(1); state_q <= S_GRD;
							end else state_q <= S_GTAIL;
						end
					end
				end
				S_GTAIL: begin
					if (req_q.action == ACT_LFREE) begin
						if (lim > pend_q && lim - pend_q > best_q)
							rsp_q.largest_gap <= lim - pend_q;
						else rsp_q.largest_gap <= best_q;
						state_q <= S_DONE;
					end else if (pend_q <= lim && lim - pend_q >= MEMB_W'(len_q)) begin
						where_q <= pend_q[ADDR_W-1:0]; fit_q <= 1'b1;
						idx_q <= '0; state_q <= S_K2RD;
					end else begin
						rsp_q.status <= ST_NO_SPACE; state_q <= S_DONE;
					end
				end
				// insert position: first entry with start > where
				S_PRD: state_q <= (cnt_q == '0) ? S_INS : S_PCHK;
				S_PCHK: begin
					if (rdata.st > where_q) begin
						fidx_q <= idx_a; idx_q <= cnt_q - CW'(1);
						state_q <= S_SHRD;
					end else if (idx_q + CW'(1) < cnt_q) begin
						idx_q <= idx_q + CW'(1); state_q <= S_PRD;
					end else begin
						idx_q <= cnt_q; state_q <= S_INS;
					end
				end
				// shift up from the top down to fidx
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (idx_q[IW-1:0] == fidx_q) state_q <= S_INS;
					else begin
						idx_q <= idx_q - CW'(1); state_q <= S_SHRD;
					end
				end
				S_INS: begin
					cnt_q <= cnt_q + CW'(1);
					rsp_q.status <= ST_OK;
					rsp_q.start_address <= where_q;
					rsp_q.region_length <= len_q;
					state_q <= S_DONE;
				end
				// erase: shift down
				S_ERD: begin
					if (idx_q < cnt_q) state_q <= S_EWR;
					else begin
						cnt_q <= cnt_q - CW'(1); state_q <= S_DONE;
					end
				end
				S_EWR: begin
					idx_q <= idx_q + CW'(1); state_q <= S_ERD;
				end
				// pack
				S_PKRD: state_q <= S_PKWR;
				S_PKWR: begin
					sum_q <= sum_q + SW'(rdata.len);
					if (idx_q + CW'(1) < cnt_q) begin
						idx_q <= idx_q + CW'(1); state_q <= S_PKRD;
					end else state_q <= S_DONE;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: rtl/core/fft_checker.sv
// Port-level checks for the first-fit region table, bound to the top level.
module fft_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input fft_pkg::rsp_t rsp
);
	import fft_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status <= ST_FULL) else $error("bad status");
	a_gap_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.largest_gap != '0 |-> rsp.status == ST_OK)
		else $error("gap with error status");

endmodule

bind first_fit_region_table_top fft_checker u_fft_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .rsp(rsp)
);
